### hw/rtl/mlsf_pkg.sv
package mlsf_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int PORT_COUNT  = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int MAC_W     = 48;
  localparam int PORT_W    = 4;
  localparam int GROUP_BIT = 40;

  // Decision codes
  localparam logic [1:0] DEC_FORWARD = 2'd0;
  localparam logic [1:0] DEC_FLOOD   = 2'd1;
  localparam logic [1:0] DEC_DROP    = 2'd2;

  typedef struct packed {
    logic [PORT_W-1:0] ingress_port;
    logic [MAC_W-1:0]  source_mac;
    logic [MAC_W-1:0]  dest_mac;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        decision;
    logic [PORT_W-1:0] egress_port;
  } out_item_t;

  typedef struct packed {
    logic [MAC_W-1:0]  addr;
    logic [PORT_W-1:0] port;
  } entry_t;

endpackage

### hw/rtl/mac_learning_switch_forwarder_unit.sv
// MAC learning bridge forwarder.
//
// Input channel (in_valid/in_ready/in_item) takes one frame header per
// transaction: ingress port, source and destination MAC. Output channel
// (out_valid/out_ready/out_item) returns one decision per header: forward
// to egress_port, flood, or drop (egress_port is zero unless forwarding).
//
// One comparator scans the address table, one stored entry per cycle, fed
// by a table memory with one write port and one registered read port. A
// header is handled in up to two scans: the source (learning), then the
// destination (lookup), which a group destination skips and floods. A group
// source or an out-of-range port is dropped with no scan. After the scans
// the result is loaded into the output register. in_ready is high only
// while no header is in work.
//
// Reset empties the table (entry count to zero); no clearing pass is run.
// While the receiver stalls, a finished decision waits behind the output
// register and the next header is not taken until the register frees up.
module mac_learning_switch_forwarder_unit
  import mlsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRC  = 2'd1;
  localparam logic [1:0] S_DST  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]         state;
  logic [1:0]         state_next;
  in_item_t           hdr;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] scan_idx;
  logic [COUNT_W-1:0] scan_idx_next;
  logic               rd_valid;
  logic               rd_valid_next;
  logic [IDX_W-1:0]   rd_idx;
  entry_t             mem_q;
  out_item_t          res;
  out_item_t          res_next;
  logic [COUNT_W-1:0] count_next;

  entry_t             table_mem [TABLE_DEPTH];
  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  entry_t             wr_entry;

  logic [MAC_W-1:0]   key;
  logic               match;
  logic               issue;
  logic               scan_end;
  logic               port_bad;
  logic               table_full;

  assign in_ready   = (state == S_IDLE);
  assign key        = (state == S_SRC) ? hdr.source_mac : hdr.dest_mac;
  assign match      = rd_valid && (mem_q.addr == key);
  assign issue      = !match && (scan_idx < count);
  assign scan_end   = match || (!issue && !rd_valid);
  assign port_bad   = (32'(in_item.ingress_port) >= PORT_COUNT);
  assign table_full = (count == COUNT_W'(TABLE_DEPTH));

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_idx] <= wr_entry;
    end
    mem_q <= table_mem[scan_idx[IDX_W-1:0]];
  end

  // Sequencer next-state and table update
  always_comb begin
    state_next    = state;
    scan_idx_next = scan_idx;
    rd_valid_next = 1'b0;
    res_next      = res;
    count_next    = count;
    wr_en         = 1'b0;
    wr_idx        = rd_idx;
    wr_entry      = '{addr: hdr.source_mac, port: hdr.ingress_port};
    unique case (state) inside
      S_IDLE: begin
        if (in_valid) begin
          scan_idx_next = '0;
          if (port_bad || in_item.source_mac[GROUP_BIT]) begin
            res_next   = '{decision: DEC_DROP, egress_port: '0};
            state_next = S_DONE;
          end else begin
            state_next = S_SRC;
          end
        end
      end
      S_SRC, S_DST: begin
        // Advance the scan: one read issued, one entry compared per cycle
        rd_valid_next = issue;
        if (issue) begin
          scan_idx_next = scan_idx + 1'b1;
        end
        if (scan_end) begin
          scan_idx_next = '0;
          rd_valid_next = 1'b0;
          if (state == S_SRC) begin
            // Learn the source: refresh a hit, append a miss if room
            if (match) begin
              wr_en = 1'b1;
            end else if (!table_full) begin
              wr_en      = 1'b1;
              wr_idx     = count[IDX_W-1:0];
              count_next = count + 1'b1;
            end
            if (hdr.dest_mac[GROUP_BIT]) begin
              res_next   = '{decision: DEC_FLOOD, egress_port: '0};
              state_next = S_DONE;
            end else begin
              state_next = S_DST;
            end
          end else begin
            // Resolve the destination
            if (!match) begin
              res_next = '{decision: DEC_FLOOD, egress_port: '0};
            end else if (mem_q.port == hdr.ingress_port) begin
              res_next = '{decision: DEC_DROP, egress_port: '0};
            end else begin
              res_next = '{decision: DEC_FORWARD, egress_port: mem_q.port};
            end
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control and payload registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_valid  <= 1'b0;
      scan_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      rd_valid <= rd_valid_next;
      scan_idx <= scan_idx_next;
      // Hold the result until taken, load when the register frees up
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      hdr <= in_item;
    end
    rd_idx <= scan_idx[IDX_W-1:0];
    res    <= res_next;
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_item <= res;
    end
  end

  // Entry count never passes the table depth
  assert property (@(posedge clk) disable iff (rst) count <= COUNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  // Table grows by at most one entry per step
  assert property (@(posedge clk) disable iff (rst)
    ##1 (count == $past(count) || count == $past(count) + 1'b1))
    else $error("entry count jumped");

  // Only a forward decision carries a port, and code 3 never appears
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_item.decision == DEC_FORWARD) ||
                   (out_item.decision == DEC_FLOOD && out_item.egress_port == '0) ||
                   (out_item.decision == DEC_DROP && out_item.egress_port == '0)))
    else $error("malformed decision");

endmodule

### tb/sv/mlsf_decision_tracker_pkg.sv
package mlsf_decision_tracker_pkg;
  import mlsf_pkg::*;

  // Mirror of the address table plus the queue of decisions still owed
  class decision_tracker;
    logic [MAC_W-1:0]  known_addr [TABLE_DEPTH];
    logic [PORT_W-1:0] known_port [TABLE_DEPTH];
    int                known_count;
    out_item_t         pending_decisions [$];
    int                errors;

    function new();
      known_count = 0;
      errors      = 0;
    endfunction

    // Return the slot holding mac among the learned entries, or -1
    function int find_station(logic [MAC_W-1:0] mac);
      for (int i = 0; i < known_count; i++) begin
        if (known_addr[i] == mac) return i;
      end
      return -1;
    endfunction

    // Learn from an accepted header and queue the decision it must produce
    function void predict_decision(in_item_t hdr);
      out_item_t want;
      int        slot;
      want.decision    = DEC_DROP;
      want.egress_port = '0;
      if (int'(hdr.ingress_port) < PORT_COUNT && !hdr.source_mac[GROUP_BIT]) begin
        // refresh a known source, append a new one while there is room
        slot = find_station(hdr.source_mac);
        if (slot >= 0) begin
          known_port[slot] = hdr.ingress_port;
        end else if (known_count < TABLE_DEPTH) begin
          known_addr[known_count] = hdr.source_mac;
          known_port[known_count] = hdr.ingress_port;
          known_count++;
        end
        // group or unknown destination floods; same-port destination drops
        if (hdr.dest_mac[GROUP_BIT]) begin
          want.decision = DEC_FLOOD;
        end else begin
          slot = find_station(hdr.dest_mac);
          if (slot < 0) begin
            want.decision = DEC_FLOOD;
          end else if (known_port[slot] == hdr.ingress_port) begin
            want.decision = DEC_DROP;
          end else begin
            want.decision    = DEC_FORWARD;
            want.egress_port = known_port[slot];
          end
        end
      end
      pending_decisions.insert(pending_decisions.size(), want);
    endfunction

    // Compare a delivered decision against the oldest one owed
    function void check_decision(out_item_t got);
      out_item_t want;
      if (pending_decisions.size() == 0) begin
        $error("decision: no transaction expected, got %0d (egress_port %0d)",
               got.decision, got.egress_port);
        errors++;
        return;
      end
      want = pending_decisions.pop_front();
      if (got.decision !== want.decision) begin
        $error("decision: expected %0d, got %0d", want.decision, got.decision);
        errors++;
      end
      if (got.egress_port !== want.egress_port) begin
        $error("egress_port: expected %0d, got %0d", want.egress_port, got.egress_port);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_decisions.size();
    endfunction
  endclass

endpackage

### tb/sv/mac_learning_switch_forwarder_unit_tb.sv
module mac_learning_switch_forwarder_unit_tb;
  import mlsf_pkg::*;
  import mlsf_decision_tracker_pkg::*;

  localparam int HEADER_COUNT  = 900;
  localparam int STATION_COUNT = 96;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  decision_tracker   tracker = new();
  logic [MAC_W-1:0]  station_mac  [STATION_COUNT];
  logic [PORT_W-1:0] station_port [STATION_COUNT];
  int                rx_cycle = 0;

  mac_learning_switch_forwarder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check delivered decisions; stall the output side in shifting phases
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_decision(out_item);
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 1500) % 3)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 9) >= 3);
      default: out_ready <= ((rx_cycle % 16) < 5);
    endcase
  end

  // Present one header and hold it until the block takes it
  task automatic send_header(input in_item_t hdr);
    in_valid <= 1'b1;
    in_item  <= hdr;
    do @(posedge clk); while (!in_ready);
    tracker.predict_decision(hdr);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off input until every owed decision has arrived
  task automatic drain_decisions();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
  endtask

  function automatic in_item_t frame(input logic [PORT_W-1:0] port,
                                     input logic [MAC_W-1:0] src,
                                     input logic [MAC_W-1:0] dst);
    in_item_t hdr;
    hdr.ingress_port = port;
    hdr.source_mac   = src;
    hdr.dest_mac     = dst;
    return hdr;
  endfunction

  function automatic logic [MAC_W-1:0] any_mac();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[MAC_W-1:0];
  endfunction

  // Mostly traffic between known stations, plus group, random and broken headers
  function automatic in_item_t make_header();
    in_item_t         hdr;
    int               s;
    int               d;
    int               pick;
    logic [MAC_W-1:0] group_mask;
    group_mask = 48'h1 << GROUP_BIT;
    pick = $urandom_range(0, 99);
    s    = $urandom_range(0, STATION_COUNT - 1);
    d    = $urandom_range(0, STATION_COUNT - 1);
    // let a station move to another port now and then
    if ($urandom_range(0, 6) == 0) begin
      station_port[s] = PORT_W'($urandom_range(0, PORT_COUNT - 1));
    end
    hdr = frame(station_port[s], station_mac[s], station_mac[d]);
    if (pick < 10) begin
      hdr.dest_mac = any_mac() | group_mask;
    end else if (pick < 13) begin
      hdr.dest_mac = '1;
    end else if (pick < 20) begin
      hdr.source_mac = any_mac() | group_mask;
    end else if (pick < 30) begin
      hdr = frame(PORT_W'($urandom_range(0, PORT_COUNT - 1)), any_mac(), any_mac());
    end else if (pick < 33) begin
      hdr.dest_mac = hdr.source_mac;
    end
    return hdr;
  endfunction

  initial begin
    int sent;
    int burst;
    int gap;
    bit paused_mid;
    for (int i = 0; i < STATION_COUNT; i++) begin
      station_mac[i]  = any_mac() & ~(48'h1 << GROUP_BIT);
      station_port[i] = PORT_W'($urandom_range(0, PORT_COUNT - 1));
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: learning, moves, same-port drop, group addresses, extremes
    send_header(frame(4'd0,  48'h0,            48'h0));
    send_header(frame(4'd15, 48'hFEFFFFFFFFFF, 48'h0));
    send_header(frame(4'd3,  48'h020000000001, 48'h001122334455));
    send_header(frame(4'd5,  48'h001122334455, 48'h020000000001));
    send_header(frame(4'd3,  48'h020000000001, 48'h001122334455));
    send_header(frame(4'd5,  48'h020000000001, 48'h001122334455));
    send_header(frame(4'd9,  48'h001122334455, 48'h020000000001));
    send_header(frame(4'd7,  48'hFFFFFFFFFFFF, 48'h020000000001));
    send_header(frame(4'd7,  48'h010000000000, 48'h0));
    send_header(frame(4'd2,  48'h001122334455, 48'hFFFFFFFFFFFF));
    send_header(frame(4'd4,  48'h020000000001, 48'h0180C2000000));
    send_header(frame(4'd0,  48'h0,            48'hFEFFFFFFFFFF));
    send_header(frame(4'd15, 48'hFEFFFFFFFFFF, 48'hFEFFFFFFFFFF));
    pause_sender(3);
    send_header(frame(4'd6,  48'h000000000001, 48'hFEFFFFFFFFFF));
    send_header(frame(4'd1,  48'hFFFFFFFFFFFF, 48'hFFFFFFFFFFFF));
    send_header(frame(4'd8,  48'h0,            48'h0));
    send_header(frame(4'd10, 48'h000000000001, 48'h0));
    drain_decisions();

    // Random bursts; no gaps while sent is 300..419, and one full drain midway
    sent       = 0;
    paused_mid = 1'b0;
    while (sent < HEADER_COUNT) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < HEADER_COUNT; i++) begin
        send_header(make_header());
        sent++;
      end
      if (!paused_mid && sent >= HEADER_COUNT / 2) begin
        drain_decisions();
        paused_mid = 1'b1;
      end else if (sent < 300 || sent >= 420) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        if (gap != 0) pause_sender(gap);
      end
    end
    drain_decisions();
    repeat (150) @(posedge clk);

    if (tracker.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
